>>> src/sct_pkg.sv
// shared types and constants for the shell command tokenizer
// token tags, character codes and the result word layout; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

   localparam int SPAN_W       = 13;
   localparam int CHAR_W       = 8;
   localparam int BUNDLE_MAX   = 3;
   localparam int BUNDLE_CNT_W = 2;
   localparam int QUEUE_DEPTH  = 5;
   localparam int LEVEL_W      = 3;

   localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
   localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;
   localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;
   localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;
   localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
   localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;
   localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

   typedef enum logic [4:0] {
      TAG_WORD       = 5'd0,
      TAG_STRING     = 5'd1,
      TAG_SEMI       = 5'd2,
      TAG_AMP        = 5'd3,
      TAG_GT         = 5'd4,
      TAG_GTGT       = 5'd5,
      TAG_BANG_GT    = 5'd6,
      TAG_BANG_GTGT  = 5'd7,
      TAG_AMP_GT     = 5'd8,
      TAG_AMP_GTGT   = 5'd9,
      TAG_PIPE       = 5'd10,
      TAG_AMP_PIPE   = 5'd11,
      TAG_AND        = 5'd12,
      TAG_OR         = 5'd13,
      TAG_LT         = 5'd14,
      TAG_LTLT       = 5'd15,
      TAG_EOF        = 5'd16,
      TAG_BAD_BANG   = 5'd17,
      TAG_OPEN_QUOTE = 5'd18,
      TAG_OVERFLOW   = 5'd19
   } tag_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_in;
      logic              has_char;
      logic              line_end;
   } req_item_type;

   typedef struct packed {
      logic              run_last;
      logic [SPAN_W-1:0] span_end;
      logic [SPAN_W-1:0] span_start;
      tag_type           tag;
   } result_type;

   // up to three tokens produced by one input word, oldest in item[0]
   typedef struct packed {
      logic [BUNDLE_CNT_W-1:0]       count;
      result_type [BUNDLE_MAX-1:0]   item;
   } bundle_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               has_room;
   } queue_status_type;

endpackage

`default_nettype wire

>>> src/sct_lexer.sv
// lexer core: state registers and single-pass byte decode
// produces a bundle of up to three tokens per accepted word; uses sct_pkg
`timescale 1ns / 1ps
`default_nettype none

module sct_lexer
   import sct_pkg::*;
#(
   parameter int MAX_LINE = 4096
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         take,
   input  wire req_item_type item,
   output bundle_type        bundle
);

   localparam int POS_W = $clog2(MAX_LINE + 1);
   localparam int EXT_W = (POS_W > SPAN_W) ? POS_W : SPAN_W;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_LINE);

   typedef enum logic [10:0] {
      ST_IDLE    = 11'b000_0000_0001,
      ST_PIPE    = 11'b000_0000_0010,
      ST_AMP     = 11'b000_0000_0100,
      ST_AMP_GT  = 11'b000_0000_1000,
      ST_BANG    = 11'b000_0001_0000,
      ST_BANG_GT = 11'b000_0010_0000,
      ST_GT      = 11'b000_0100_0000,
      ST_LT      = 11'b000_1000_0000,
      ST_STRING  = 11'b001_0000_0000,
      ST_WORD    = 11'b010_0000_0000,
      ST_SKIP    = 11'b100_0000_0000
   } lex_state_type;

   lex_state_type    state_ff, state_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] begin_ff, begin_in;

   function automatic result_type mk(input tag_type t, input logic [EXT_W-1:0] s,
                                     input logic [EXT_W-1:0] e, input logic last);
      result_type r;
      r.tag        = t;
      r.span_start = s[SPAN_W-1:0];
      r.span_end   = e[SPAN_W-1:0];
      r.run_last   = last;
      return r;
   endfunction

   function automatic logic ends_word(input logic [CHAR_W-1:0] c);
      return (c == CH_PIPE) || (c == CH_GT) || (c == CH_SPACE) || (c == CH_BANG) ||
             (c == CH_QUOTE) || (c == CH_SEMI) || (c == CH_AMP) || (c == CH_NL) ||
             (c == CH_TAB);
   endfunction

   always_comb begin
      logic [CHAR_W-1:0]     c;
      logic [EXT_W-1:0]      p;
      logic [EXT_W-1:0]      b;
      logic [EXT_W-1:0]      pe;
      logic [EXT_W-1:0]      be;
      lex_state_type         st_mid;
      logic [POS_W-1:0]      pos_mid;
      logic [POS_W-1:0]      begin_mid;
      logic                  do_start;
      logic                  err;
      logic [3:0]            v;
      result_type [3:0]      r;
      logic [BUNDLE_CNT_W-1:0] n;

      c         = item.char_in;
      p         = EXT_W'(pos_ff);
      b         = EXT_W'(begin_ff);
      pe        = '0;
      be        = '0;
      st_mid    = state_ff;
      pos_mid   = pos_ff;
      begin_mid = begin_ff;
      do_start  = 1'b0;
      err       = 1'b0;
      v         = '0;
      r         = '0;

      // byte stage: close the pending token and maybe start a new one
      if (item.has_char && (state_ff != ST_SKIP)) begin
         if (pos_ff >= POS_LIMIT) begin
            v[0]   = 1'b1;
            r[0]   = mk(TAG_OVERFLOW, p, p, 1'b1);
            st_mid = ST_SKIP;
         end else begin
            case (state_ff)
               ST_PIPE: begin
                  if (c == CH_PIPE) begin
                     v[0] = 1'b1; r[0] = mk(TAG_OR, b, p + 1'b1, 1'b0); st_mid = ST_IDLE;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_PIPE, b, b + 1'b1, 1'b0); do_start = 1'b1;
                  end
               end
               ST_AMP: begin
                  if (c == CH_PIPE) begin
                     v[0] = 1'b1; r[0] = mk(TAG_AMP_PIPE, b, p + 1'b1, 1'b0);
                     st_mid = ST_IDLE;
                  end else if (c == CH_AMP) begin
                     v[0] = 1'b1; r[0] = mk(TAG_AND, b, p + 1'b1, 1'b0); st_mid = ST_IDLE;
                  end else if (c == CH_GT) begin
                     st_mid = ST_AMP_GT;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_AMP, b, b + 1'b1, 1'b0); do_start = 1'b1;
                  end
               end
               ST_AMP_GT: begin
                  if (c == CH_GT) begin
                     v[0] = 1'b1; r[0] = mk(TAG_AMP_GTGT, b, p + 1'b1, 1'b0);
                     st_mid = ST_IDLE;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_AMP_GT, b, b + 2'd2, 1'b0); do_start = 1'b1;
                  end
               end
               ST_BANG: begin
                  if (c == CH_GT) begin
                     st_mid = ST_BANG_GT;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_BAD_BANG, b, b + 1'b1, 1'b1); st_mid = ST_SKIP;
                  end
               end
               ST_BANG_GT: begin
                  if (c == CH_GT) begin
                     v[0] = 1'b1; r[0] = mk(TAG_BANG_GTGT, b, p + 1'b1, 1'b0);
                     st_mid = ST_IDLE;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_BANG_GT, b, b + 2'd2, 1'b0); do_start = 1'b1;
                  end
               end
               ST_GT: begin
                  if (c == CH_GT) begin
                     v[0] = 1'b1; r[0] = mk(TAG_GTGT, b, p + 1'b1, 1'b0); st_mid = ST_IDLE;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_GT, b, b + 1'b1, 1'b0); do_start = 1'b1;
                  end
               end
               ST_LT: begin
                  if (c == CH_LT) begin
                     v[0] = 1'b1; r[0] = mk(TAG_LTLT, b, p + 1'b1, 1'b0); st_mid = ST_IDLE;
                  end else begin
                     v[0] = 1'b1; r[0] = mk(TAG_LT, b, b + 1'b1, 1'b0); do_start = 1'b1;
                  end
               end
               ST_STRING: begin
                  if (c == CH_QUOTE) begin
                     v[0] = 1'b1; r[0] = mk(TAG_STRING, b, p + 1'b1, 1'b0); st_mid = ST_IDLE;
                  end
               end
               ST_WORD: begin
                  if (ends_word(c)) begin
                     v[0] = 1'b1; r[0] = mk(TAG_WORD, b, p, 1'b0); do_start = 1'b1;
                  end
               end
               default: begin
                  do_start = 1'b1;
               end
            endcase

            if (do_start) begin
               begin_mid = pos_ff;
               if ((c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL)) begin
                  st_mid = ST_IDLE;
               end else if (c == CH_SEMI) begin
                  v[1] = 1'b1; r[1] = mk(TAG_SEMI, p, p + 1'b1, 1'b0); st_mid = ST_IDLE;
               end else if (c == CH_PIPE) begin
                  st_mid = ST_PIPE;
               end else if (c == CH_AMP) begin
                  st_mid = ST_AMP;
               end else if (c == CH_BANG) begin
                  st_mid = ST_BANG;
               end else if (c == CH_GT) begin
                  st_mid = ST_GT;
               end else if (c == CH_LT) begin
                  st_mid = ST_LT;
               end else if (c == CH_QUOTE) begin
                  st_mid = ST_STRING;
               end else begin
                  st_mid = ST_WORD;
               end
            end
            pos_mid = pos_ff + 1'b1;
         end
      end

      // end of line: flush the pending token, then eof unless an error closed it
      state_in = st_mid;
      pos_in   = pos_mid;
      begin_in = begin_mid;
      if (item.line_end) begin
         pe = EXT_W'(pos_mid);
         be = EXT_W'(begin_mid);
         case (st_mid)
            ST_PIPE:    begin v[2] = 1'b1; r[2] = mk(TAG_PIPE, be, be + 1'b1, 1'b0); end
            ST_AMP:     begin v[2] = 1'b1; r[2] = mk(TAG_AMP, be, be + 1'b1, 1'b0); end
            ST_AMP_GT:  begin v[2] = 1'b1; r[2] = mk(TAG_AMP_GT, be, be + 2'd2, 1'b0); end
            ST_BANG: begin
               v[2] = 1'b1; r[2] = mk(TAG_BAD_BANG, be, be + 1'b1, 1'b1); err = 1'b1;
            end
            ST_BANG_GT: begin v[2] = 1'b1; r[2] = mk(TAG_BANG_GT, be, be + 2'd2, 1'b0); end
            ST_GT:      begin v[2] = 1'b1; r[2] = mk(TAG_GT, be, be + 1'b1, 1'b0); end
            ST_LT:      begin v[2] = 1'b1; r[2] = mk(TAG_LT, be, be + 1'b1, 1'b0); end
            ST_STRING: begin
               v[2] = 1'b1; r[2] = mk(TAG_OPEN_QUOTE, be, pe, 1'b1); err = 1'b1;
            end
            ST_WORD:    begin v[2] = 1'b1; r[2] = mk(TAG_WORD, be, pe, 1'b0); end
            ST_SKIP:    begin err = 1'b1; end
            default:    begin end
         endcase
         if (!err) begin
            v[3] = 1'b1;
            r[3] = mk(TAG_EOF, pe, pe, 1'b1);
         end
         state_in = ST_IDLE;
         pos_in   = '0;
         begin_in = '0;
      end

      if (!take) begin
         state_in = state_ff;
         pos_in   = pos_ff;
         begin_in = begin_ff;
         v        = '0;
      end

      // pack the raised slots in order, keeping at most three
      bundle = '0;
      n      = '0;
      for (int k = 0; k < 4; k++) begin
         if (v[k] && (n < BUNDLE_CNT_W'(BUNDLE_MAX))) begin
            bundle.item[n] = r[k];
            n = n + 1'b1;
         end
      end
      bundle.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         begin_ff <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         begin_ff <= begin_in;
      end
   end

endmodule

`default_nettype wire

>>> src/sct_out_queue.sv
// result queue: five-entry shift queue that takes a whole token bundle
// and hands one token per handshake downstream; uses sct_pkg
`timescale 1ns / 1ps
`default_nettype none

module sct_out_queue
   import sct_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type bundle,
   input  wire logic       rsp_tready,
   output logic            rsp_tvalid,
   output result_type      head,
   output queue_status_type status
);

   result_type [QUEUE_DEPTH-1:0] slot_ff, slot_in;
   logic [LEVEL_W-1:0]           level_ff, level_in;

   logic pop;

   assign rsp_tvalid      = (level_ff != '0);
   assign head            = slot_ff[0];
   assign pop             = rsp_tvalid && rsp_tready;
   // room for a full bundle whatever the receiver does this cycle
   assign status.has_room = (level_ff <= LEVEL_W'(QUEUE_DEPTH - BUNDLE_MAX));
   assign status.level    = level_ff;

   always_comb begin
      result_type [QUEUE_DEPTH-1:0] shifted;
      logic [LEVEL_W-1:0]           base;
      logic [LEVEL_W-1:0]           k;

      shifted = slot_ff;
      if (pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            shifted[i] = slot_ff[i + 1];
         end
      end
      base    = level_ff - LEVEL_W'(pop);
      slot_in = shifted;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         k = LEVEL_W'(i) - base;
         if (push && (LEVEL_W'(i) >= base) && (k < LEVEL_W'(bundle.count))) begin
            slot_in[i] = bundle.item[k[BUNDLE_CNT_W-1:0]];
         end
      end
      level_in = base + (push ? LEVEL_W'(bundle.count) : '0);
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

endmodule

`default_nettype wire

>>> src/shell_command_tokenizer.sv
// shell command tokenizer top level
// joins the lexer core and the result queue; uses sct_pkg, sct_lexer, sct_out_queue
//
// usage
//   the req channel takes one word per command-line byte: tdata is the byte,
//   tuser flags that the byte is present (an end-only word has it low), and
//   tlast closes the line.  the rsp channel gives one token per word: tag,
//   span start and span end; tlast marks the final token of a line (eof or
//   an error token).
//   each accepted word is decoded in the cycle it is taken: the lexer state
//   registers update at once and the zero to three tokens it causes land in
//   a five-entry result queue.  with the queue empty, the first of them shows
//   on rsp the cycle after acceptance.
//   throughput is one byte per cycle while each byte yields at most one
//   token and rsp_tready is high; the queue then drains one token per
//   cycle, so a burst of operators at a line end can hold req off until they drain.
//   req_tready is high while the queue can take a full bundle of three.
//   a stalled receiver fills the queue and then req_tready drops; nothing
//   is lost or repeated.
//   reset (synchronous) returns the lexer to idle at position zero and
//   empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module shell_command_tokenizer
   import sct_pkg::*;
#(
   parameter int MAX_LINE = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_in[7:0]
   input  wire logic [0:0]  req_tuser,   // has_char[0]
   input  wire logic        req_tlast,   // line_end
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // tag[4:0], span_start[17:5], span_end[30:18], zero[31]
   output logic             rsp_tlast    // run_last
);

   req_item_type     item;
   bundle_type       bundle;
   result_type       head;
   queue_status_type q_status;
   logic             take;

   assign item.char_in  = req_tdata;
   assign item.has_char = req_tuser[0];
   assign item.line_end = req_tlast;

   assign req_tready = q_status.has_room;
   assign take       = req_tvalid && req_tready;

   // decode the word against the current lexer state
   sct_lexer #(
      .MAX_LINE(MAX_LINE)
   ) u_lexer (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (item),
      .bundle(bundle)
   );

   // serialize the bundle onto the response stream
   sct_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .bundle    (bundle),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .head      (head),
      .status    (q_status)
   );

   assign rsp_tdata = {1'b0, head.span_end, head.span_start, head.tag};
   assign rsp_tlast = head.run_last;

   // an accepted bundle always fits in the queue
   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      take |-> (({1'b0, q_status.level} + {2'b00, bundle.count}) <= QUEUE_DEPTH))
      else $error("result queue overfilled");

   // a line end that yields tokens closes with a last-marked token
   a_line_closes: assert property (@(posedge clock) disable iff (reset)
      (take && req_tlast && (bundle.count != '0)) |->
         bundle.item[bundle.count - 1'b1].run_last)
      else $error("line end without closing token");

   // a stalled receiver never loses queued tokens
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (q_status.level >= $past(q_status.level)))
      else $error("queued token dropped during stall");

endmodule

`default_nettype wire

>>> tb/shell_command_tokenizer_test.sv
// self-checking bench for the shell command tokenizer: byte stream in, tagged spans out
// holds its own token predictor and an in-order queue of expected tokens; needs sct_pkg
// and the shell_command_tokenizer rtl
`timescale 1ns / 1ps

module shell_command_tokenizer_test;
   import sct_pkg::*;

   localparam int LINE_LIMIT = 4096;
   localparam int CYCLE_LIMIT = 600000;
   localparam int REPORT_MAX = 10;

   // lexer states of the predictor
   typedef enum logic [3:0] {
      LX_IDLE, LX_PIPE, LX_AMP, LX_AMP_GT, LX_BANG, LX_BANG_GT,
      LX_GT, LX_LT, LX_STRING, LX_WORD, LX_SKIP
   } lex_state_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // char_in[7:0]
   logic [0:0]  req_tuser = 1'b0;    // has_char[0]
   logic        req_tlast = 1'b0;    // line_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // tag[4:0], span_start[17:5], span_end[30:18], zero[31]
   logic        rsp_tlast;           // run_last

   // predictor state
   lex_state_type lex_st = LX_IDLE;
   int unsigned   line_pos = 0;
   int unsigned   tok_begin = 0;
   result_type    pending_tokens[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  items_sent = 0;
   int  hold_len = 0;
   bit  idle_on = 1'b1;

   string op_text [14] = '{";", "|", "||", "&", "&|", "&&", "&>", "&>>",
                           "!>", "!>>", ">", ">>", "<", "<<"};

   shell_command_tokenizer #(
      .MAX_LINE(LINE_LIMIT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic bit breaks_word(logic [7:0] c);
      return c == CH_PIPE || c == CH_GT || c == CH_SPACE || c == CH_BANG ||
             c == CH_QUOTE || c == CH_SEMI || c == CH_AMP || c == CH_NL || c == CH_TAB;
   endfunction

   function automatic void expect_token(tag_type tag, int unsigned first,
                                        int unsigned past, logic last);
      result_type t;
      t.tag        = tag;
      t.span_start = first[SPAN_W-1:0];
      t.span_end   = past[SPAN_W-1:0];
      t.run_last   = last;
      pending_tokens.push_back(t);
   endfunction

   // byte c at position p with nothing pending
   function automatic void begin_token(logic [7:0] c, int unsigned p);
      tok_begin = p;
      case (c)
         CH_SPACE, CH_TAB, CH_NL: lex_st = LX_IDLE;
         CH_SEMI: begin
            expect_token(TAG_SEMI, p, p + 1, 1'b0);
            lex_st = LX_IDLE;
         end
         CH_PIPE:  lex_st = LX_PIPE;
         CH_AMP:   lex_st = LX_AMP;
         CH_BANG:  lex_st = LX_BANG;
         CH_GT:    lex_st = LX_GT;
         CH_LT:    lex_st = LX_LT;
         CH_QUOTE: lex_st = LX_STRING;
         default:  lex_st = LX_WORD;
      endcase
   endfunction

   function automatic void take_char(logic [7:0] c, int unsigned p);
      int unsigned b;
      b = tok_begin;
      case (lex_st)
         LX_PIPE: begin
            if (c == CH_PIPE) begin
               expect_token(TAG_OR, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else begin
               expect_token(TAG_PIPE, b, b + 1, 1'b0);
               begin_token(c, p);
            end
         end
         LX_AMP: begin
            if (c == CH_PIPE) begin
               expect_token(TAG_AMP_PIPE, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else if (c == CH_AMP) begin
               expect_token(TAG_AND, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else if (c == CH_GT) begin
               lex_st = LX_AMP_GT;
            end else begin
               expect_token(TAG_AMP, b, b + 1, 1'b0);
               begin_token(c, p);
            end
         end
         LX_AMP_GT: begin
            if (c == CH_GT) begin
               expect_token(TAG_AMP_GTGT, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else begin
               expect_token(TAG_AMP_GT, b, b + 2, 1'b0);
               begin_token(c, p);
            end
         end
         LX_BANG: begin
            if (c == CH_GT) begin
               lex_st = LX_BANG_GT;
            end else begin
               expect_token(TAG_BAD_BANG, b, b + 1, 1'b1);
               lex_st = LX_SKIP;
            end
         end
         LX_BANG_GT: begin
            if (c == CH_GT) begin
               expect_token(TAG_BANG_GTGT, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else begin
               expect_token(TAG_BANG_GT, b, b + 2, 1'b0);
               begin_token(c, p);
            end
         end
         LX_GT: begin
            if (c == CH_GT) begin
               expect_token(TAG_GTGT, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else begin
               expect_token(TAG_GT, b, b + 1, 1'b0);
               begin_token(c, p);
            end
         end
         LX_LT: begin
            if (c == CH_LT) begin
               expect_token(TAG_LTLT, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end else begin
               expect_token(TAG_LT, b, b + 1, 1'b0);
               begin_token(c, p);
            end
         end
         LX_STRING: begin
            if (c == CH_QUOTE) begin
               expect_token(TAG_STRING, b, p + 1, 1'b0);
               lex_st = LX_IDLE;
            end
         end
         LX_WORD: begin
            if (breaks_word(c)) begin
               expect_token(TAG_WORD, b, p, 1'b0);
               begin_token(c, p);
            end
         end
         LX_SKIP: ;
         default: begin_token(c, p);
      endcase
   endfunction

   // flush the pending token, then eof unless the line already ended in an error
   function automatic void close_line();
      int unsigned b;
      bit          err;
      b   = tok_begin;
      err = 1'b0;
      case (lex_st)
         LX_PIPE:    expect_token(TAG_PIPE, b, b + 1, 1'b0);
         LX_AMP:     expect_token(TAG_AMP, b, b + 1, 1'b0);
         LX_AMP_GT:  expect_token(TAG_AMP_GT, b, b + 2, 1'b0);
         LX_BANG: begin
            expect_token(TAG_BAD_BANG, b, b + 1, 1'b1);
            err = 1'b1;
         end
         LX_BANG_GT: expect_token(TAG_BANG_GT, b, b + 2, 1'b0);
         LX_GT:      expect_token(TAG_GT, b, b + 1, 1'b0);
         LX_LT:      expect_token(TAG_LT, b, b + 1, 1'b0);
         LX_STRING: begin
            expect_token(TAG_OPEN_QUOTE, b, line_pos, 1'b1);
            err = 1'b1;
         end
         LX_WORD:    expect_token(TAG_WORD, b, line_pos, 1'b0);
         LX_SKIP:    err = 1'b1;
         default: ;
      endcase
      if (!err)
         expect_token(TAG_EOF, line_pos, line_pos, 1'b1);
      lex_st    = LX_IDLE;
      line_pos  = 0;
      tok_begin = 0;
   endfunction

   function automatic void lex_byte(logic [7:0] c, logic has, logic endl);
      if (has && lex_st != LX_SKIP) begin
         if (line_pos >= LINE_LIMIT) begin
            // too long: pending token is dropped
            expect_token(TAG_OVERFLOW, line_pos, line_pos, 1'b1);
            lex_st = LX_SKIP;
         end else begin
            take_char(c, line_pos);
            line_pos++;
         end
      end
      if (endl)
         close_line();
   endfunction

   // ---------------------------------------------------------------- driving

   // one word on req; inputs change on the falling edge, acceptance seen on the rising
   task automatic feed_byte(input logic [7:0] ch, input logic has, input logic endl);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ch;
      req_tuser  <= has;
      req_tlast  <= endl;
      do @(posedge clock); while (!req_tready);
      lex_byte(ch, has, endl);
      if (has || endl)
         items_sent++;
      @(negedge clock);
   endtask

   task automatic feed_text(input string text, input bit ends);
      for (int i = 0; i < text.len(); i++)
         feed_byte(text[i], 1'b1, ends && i == text.len() - 1);
   endtask

   // end-only word; the byte lane carries noise
   task automatic end_line();
      feed_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   function automatic logic [7:0] random_word_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (breaks_word(c) || c == CH_QUOTE || c == CH_LT);
      return c;
   endfunction

   // receiver: random ready bursts, or one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      forever begin
         if (hold_len > 0) begin
            n = hold_len;
            hold_len = 0;
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin : check_tokens
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("unexpected token: tag %0d span %0d..%0d last %0b",
                        rsp_tdata[4:0], rsp_tdata[17:5], rsp_tdata[30:18], rsp_tlast);
         end else begin
            want = pending_tokens.pop_front();
            if (rsp_tdata[4:0] !== want.tag || rsp_tdata[17:5] !== want.span_start ||
                rsp_tdata[30:18] !== want.span_end || rsp_tlast !== want.run_last) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("mismatch: want %0d %0d..%0d %0b, got %0d %0d..%0d %0b",
                           want.tag, want.span_start, want.span_end, want.run_last,
                           rsp_tdata[4:0], rsp_tdata[17:5], rsp_tdata[30:18], rsp_tlast);
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------- tests

   // all fourteen operators back to back, longest match splits them; last byte closes the line
   task automatic test_operators();
      feed_text("||&|&&&>>&>!>>!><<<;>>>|&", 1'b1);
   endtask

   // '<' inside a word, quoted operators, extreme byte values, separators, empty and end-only words
   task automatic test_words_and_strings();
      feed_text("a<b\"q !|;\"", 1'b0);
      feed_byte(8'h00, 1'b1, 1'b0);
      feed_byte(8'hff, 1'b1, 1'b0);
      feed_text(" \t\n", 1'b0);
      feed_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end_line();
      end_line();
      feed_text("xyz", 1'b1);
   endtask

   // lone bang mid line and at line end, open quote, and bang-gt closed by the line end
   task automatic test_error_tokens();
      feed_text("ab !c>d", 1'b1);
      feed_text("!", 1'b1);
      feed_text("x \"open", 1'b1);
      feed_text("!>", 1'b1);
   endtask

   // receiver holds off while ';' words keep coming, so the result queue fills
   task automatic test_backpressure();
      // nothing offered while the hold-off is being armed
      req_tvalid <= 1'b0;
      @(negedge clock);
      hold_len = 150;
      wait (hold_len == 0);
      for (int i = 0; i < 40; i++)
         feed_byte(CH_SEMI, 1'b1, i == 39);
   endtask

   // one line of mostly well-formed tokens with random content, plus some noise
   task automatic random_line();
      bit [8:0]   line_q[$];
      int         pieces, kind, len, pick;
      bit         fold;
      pieces = $urandom_range(1, 6);
      for (int i = 0; i < pieces; i++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            len = $urandom_range(1, 6);
            line_q.push_back({1'b1, random_word_byte()});
            for (int k = 1; k < len; k++)
               line_q.push_back({1'b1, ($urandom_range(0, 5) == 0) ? CH_LT
                                                                  : random_word_byte()});
         end else if (kind < 50) begin
            len = $urandom_range(0, 5);
            line_q.push_back({1'b1, CH_QUOTE});
            for (int k = 0; k < len; k++) begin
               logic [7:0] c;
               do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE);
               line_q.push_back({1'b1, c});
            end
            // now and then the string is left open
            if ($urandom_range(0, 9) != 0)
               line_q.push_back({1'b1, CH_QUOTE});
         end else if (kind < 75) begin
            pick = $urandom_range(0, 13);
            for (int k = 0; k < op_text[pick].len(); k++)
               line_q.push_back({1'b1, op_text[pick][k]});
         end else if (kind < 90) begin
            len = $urandom_range(1, 3);
            for (int k = 0; k < len; k++) begin
               pick = $urandom_range(0, 2);
               line_q.push_back({1'b1, pick == 0 ? CH_SPACE : pick == 1 ? CH_TAB : CH_NL});
            end
         end else if (kind < 95) begin
            line_q.push_back({1'b1, 8'($urandom_range(0, 255))});
         end else if (kind < 97) begin
            line_q.push_back({1'b0, 8'($urandom_range(0, 255))});
         end else begin
            // lone bang
            line_q.push_back({1'b1, CH_BANG});
            line_q.push_back({1'b1, random_word_byte()});
         end
      end
      fold = 1'($urandom_range(0, 1));
      for (int k = 0; k < line_q.size(); k++)
         feed_byte(line_q[k][7:0], line_q[k][8], fold && k == line_q.size() - 1);
      if (!fold)
         end_line();
   endtask

   task automatic test_random_lines(input int count);
      int target;
      target = items_sent + count;
      while (items_sent < target)
         random_line();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_operators();
      test_words_and_strings();
      test_error_tokens();
      test_backpressure();
      test_random_lines(70);
      // closing stretch runs with no idle gaps on req and the receiver always ready
      idle_on = 1'b0;
      test_random_lines(30);

      req_tvalid <= 1'b0;
      while (pending_tokens.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
